// ===== src/obb_overlap_test_2d_macros.svh =====
// assertion macros shared by the box overlap test rtl
`ifndef OBB_OVERLAP_TEST_2D_MACROS_SVH
`define OBB_OVERLAP_TEST_2D_MACROS_SVH

// same-cycle implication, checked on clk with reset masked
`define OBBT_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk with reset masked
`define OBBT_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/obbt_pkg.sv =====
// widths, types and helpers shared by the box overlap test pipeline
`timescale 1ns / 1ps

package obbt_pkg;

    // input field widths
    localparam int W_CEN  = 24;
    localparam int W_HALF = 16;
    localparam int W_DIR  = 16;

    // packed transaction widths
    localparam int W_IN_DATA  = 4 * W_CEN + 4 * W_HALF + 4 * W_DIR;
    localparam int W_OUT_DATA = 8;

    // internal datapath widths
    localparam int W_OFF  = W_CEN + 1;            // centre minus half extent
    localparam int W_EU   = W_HALF + 1 + W_DIR;   // extent times direction
    localparam int W_SQ   = 2 * W_DIR;            // direction products
    localparam int W_DOT  = W_SQ + 1;             // sum of two direction products
    localparam int W_MAG  = W_SQ;                 // magnitude of a direction dot
    localparam int W_L    = 41;                   // centre difference
    localparam int W_AX   = W_DIR + 1;            // axis component, allows negation
    localparam int W_WM   = W_HALF + W_MAG;       // extent times magnitude
    localparam int W_R    = W_WM + 2;             // sum of three weighted terms
    localparam int W_LD   = W_L + W_AX;           // centre offset times axis
    localparam int W_PROJ = W_LD + 1;             // projection of centre offset
    localparam int W_D    = W_LD;                 // magnitude of that projection

    // rotation term scale: directions carry 14 fraction bits
    localparam int ROT_SHIFT = 14;

    // number of separating axes tested
    localparam int N_AXES = 4;

    // load enables handed to each axis unit
    typedef struct packed {
        logic ld_prod;
        logic ld_sum;
    } obbt_stage_en_t;

    // magnitude of a sum of two direction products
    function automatic logic [W_MAG-1:0] abs_dot(input logic signed [W_DOT-1:0] v);
        logic signed [W_DOT-1:0] n;
        begin
            n = -v;
            abs_dot = v[W_DOT-1] ? n[W_MAG-1:0] : v[W_MAG-1:0];
        end
    endfunction

    // magnitude of a centre offset projection
    function automatic logic [W_D-1:0] abs_proj(input logic signed [W_PROJ-1:0] v);
        logic signed [W_PROJ-1:0] n;
        begin
            n = -v;
            abs_proj = v[W_PROJ-1] ? n[W_D-1:0] : v[W_D-1:0];
        end
    endfunction

endpackage

// ===== src/obbt_axis.sv =====
// one separating axis: weighted radius and centre projection, two register stages
`timescale 1ns / 1ps

module obbt_axis
    import obbt_pkg::*;
(
    input  logic                         clk,
    input  obbt_stage_en_t               en,
    input  logic        [W_HALF-1:0]     w0,
    input  logic        [W_HALF-1:0]     w1,
    input  logic        [W_HALF-1:0]     w2,
    input  logic        [W_MAG-1:0]      m0,
    input  logic        [W_MAG-1:0]      m1,
    input  logic        [W_MAG-1:0]      m2,
    input  logic signed [W_L-1:0]        lx,
    input  logic signed [W_L-1:0]        ly,
    input  logic signed [W_AX-1:0]       dx,
    input  logic signed [W_AX-1:0]       dy,
    output logic                         sep
);

    logic        [W_WM-1:0] t0_reg, t1_reg, t2_reg;
    logic        [W_WM-1:0] t0_next, t1_next, t2_next;
    logic signed [W_LD-1:0] px_reg, py_reg;
    logic signed [W_LD-1:0] px_next, py_next;
    logic        [W_R-1:0]  r_reg, r_next;
    logic        [W_D-1:0]  d_reg, d_next;
    logic signed [W_PROJ-1:0] proj;

    // extent-weighted magnitudes and offset projection products
    always_comb
    begin
        t0_next = W_WM'(w0) * W_WM'(m0);
        t1_next = W_WM'(w1) * W_WM'(m1);
        t2_next = W_WM'(w2) * W_WM'(m2);
        px_next = lx * dx;
        py_next = ly * dy;
    end

    always_ff @(posedge clk)
    begin
        if (en.ld_prod)
        begin
            t0_reg <= t0_next;
            t1_reg <= t1_next;
            t2_reg <= t2_next;
            px_reg <= px_next;
            py_reg <= py_next;
        end
    end

    // radius sum and projection magnitude
    always_comb
    begin
        r_next = W_R'(t0_reg) + W_R'(t1_reg) + W_R'(t2_reg);
        proj   = W_PROJ'(px_reg) + W_PROJ'(py_reg);
        d_next = abs_proj(proj);
    end

    always_ff @(posedge clk)
    begin
        if (en.ld_sum)
        begin
            r_reg <= r_next;
            d_reg <= d_next;
        end
    end

    // touching counts as separated
    assign sep = (W_D'(r_reg) <= d_reg);

endmodule

// ===== src/obb_overlap_test_2d.sv =====
// Two-box oriented overlap test in 2D by separating axes. Each input transaction carries
// one box pair; the result transaction carries overlap = 1 when none of the four box axes
// separates them (touching counts as separated). The block is a five-stage pipeline:
// products, rotated-centre and axis-dot sums, weighted products per axis, per-axis sums,
// then the compare into the output register. It takes one pair per clock while the output is
// not stalled; each result is presented from the output register once its pair has moved
// through every stage. A stall at the output backs up through the per-stage ready chain, so
// bubbles are squeezed out and nothing is dropped or repeated.
`timescale 1ns / 1ps
`include "obb_overlap_test_2d_macros.svh"

module obb_overlap_test_2d
    import obbt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // a_center_x, a_center_y, a_half_x, a_half_y, a_dir_x, a_dir_y,
    // b_center_x, b_center_y, b_half_x, b_half_y, b_dir_x, b_dir_y
    input  logic [W_IN_DATA-1:0]   s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // overlap, then zero padding
    output logic [W_OUT_DATA-1:0]  m_axis_tdata
);

    // input field unpacking
    logic signed [W_CEN-1:0]  acx, acy, bcx, bcy;
    logic        [W_HALF-1:0] aex, aey, bex, bey;
    logic signed [W_DIR-1:0]  aux, auy, bux, buy;

    assign acx = s_axis_tdata[23:0];
    assign acy = s_axis_tdata[47:24];
    assign aex = s_axis_tdata[63:48];
    assign aey = s_axis_tdata[79:64];
    assign aux = s_axis_tdata[95:80];
    assign auy = s_axis_tdata[111:96];
    assign bcx = s_axis_tdata[135:112];
    assign bcy = s_axis_tdata[159:136];
    assign bex = s_axis_tdata[175:160];
    assign bey = s_axis_tdata[191:176];
    assign bux = s_axis_tdata[207:192];
    assign buy = s_axis_tdata[223:208];

    // valid bits and ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5 = !v5_reg || m_axis_tready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_axis_tready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= s_axis_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // stage 1: pivot offsets, rotation products, direction products
    logic signed [W_HALF:0]   aex_s, aey_s, bex_s, bey_s;
    logic signed [W_OFF-1:0]  a_offx_next, a_offy_next, b_offx_next, b_offy_next;
    logic signed [W_EU-1:0]   a_exux_next, a_eyuy_next, a_exuy_next, a_eyux_next;
    logic signed [W_EU-1:0]   b_exux_next, b_eyuy_next, b_exuy_next, b_eyux_next;
    logic signed [W_SQ-1:0]   sq_axx_next, sq_ayy_next, sq_bxx_next, sq_byy_next;
    logic signed [W_SQ-1:0]   x_axbx_next, x_ayby_next, x_axby_next, x_aybx_next;

    logic signed [W_OFF-1:0]  a_offx_reg, a_offy_reg, b_offx_reg, b_offy_reg;
    logic signed [W_EU-1:0]   a_exux_reg, a_eyuy_reg, a_exuy_reg, a_eyux_reg;
    logic signed [W_EU-1:0]   b_exux_reg, b_eyuy_reg, b_exuy_reg, b_eyux_reg;
    logic signed [W_SQ-1:0]   sq_axx_reg, sq_ayy_reg, sq_bxx_reg, sq_byy_reg;
    logic signed [W_SQ-1:0]   x_axbx_reg, x_ayby_reg, x_axby_reg, x_aybx_reg;
    logic        [W_HALF-1:0] aex1_reg, aey1_reg, bex1_reg, bey1_reg;
    logic signed [W_DIR-1:0]  aux1_reg, auy1_reg, bux1_reg, buy1_reg;

    always_comb
    begin
        aex_s = $signed({1'b0, aex});
        aey_s = $signed({1'b0, aey});
        bex_s = $signed({1'b0, bex});
        bey_s = $signed({1'b0, bey});
        a_offx_next = acx - aex_s;
        a_offy_next = acy - aey_s;
        b_offx_next = bcx - bex_s;
        b_offy_next = bcy - bey_s;
        a_exux_next = aex_s * aux;
        a_eyuy_next = aey_s * auy;
        a_exuy_next = aex_s * auy;
        a_eyux_next = aey_s * aux;
        b_exux_next = bex_s * bux;
        b_eyuy_next = bey_s * buy;
        b_exuy_next = bex_s * buy;
        b_eyux_next = bey_s * bux;
        sq_axx_next = aux * aux;
        sq_ayy_next = auy * auy;
        sq_bxx_next = bux * bux;
        sq_byy_next = buy * buy;
        x_axbx_next = aux * bux;
        x_ayby_next = auy * buy;
        x_axby_next = aux * buy;
        x_aybx_next = auy * bux;
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            a_offx_reg <= a_offx_next;
            a_offy_reg <= a_offy_next;
            b_offx_reg <= b_offx_next;
            b_offy_reg <= b_offy_next;
            a_exux_reg <= a_exux_next;
            a_eyuy_reg <= a_eyuy_next;
            a_exuy_reg <= a_exuy_next;
            a_eyux_reg <= a_eyux_next;
            b_exux_reg <= b_exux_next;
            b_eyuy_reg <= b_eyuy_next;
            b_exuy_reg <= b_exuy_next;
            b_eyux_reg <= b_eyux_next;
            sq_axx_reg <= sq_axx_next;
            sq_ayy_reg <= sq_ayy_next;
            sq_bxx_reg <= sq_bxx_next;
            sq_byy_reg <= sq_byy_next;
            x_axbx_reg <= x_axbx_next;
            x_ayby_reg <= x_ayby_next;
            x_axby_reg <= x_axby_next;
            x_aybx_reg <= x_aybx_next;
            aex1_reg   <= aex;
            aey1_reg   <= aey;
            bex1_reg   <= bex;
            bey1_reg   <= bey;
            aux1_reg   <= aux;
            auy1_reg   <= auy;
            bux1_reg   <= bux;
            buy1_reg   <= buy;
        end
    end

    // stage 2: rotated centre difference and axis dot magnitudes
    logic signed [W_L-1:0]    off_dx, off_dy;
    logic signed [W_L-1:0]    lx_next, ly_next;
    logic signed [W_DOT-1:0]  na_sum, nb_sum, p_sum, s_sum;
    logic        [W_MAG-1:0]  na_next, nb_next, mp_next, ms_next;

    logic signed [W_L-1:0]    lx_reg, ly_reg;
    logic        [W_MAG-1:0]  na_reg, nb_reg, mp_reg, ms_reg;
    logic        [W_HALF-1:0] aex2_reg, aey2_reg, bex2_reg, bey2_reg;
    logic signed [W_DIR-1:0]  aux2_reg, auy2_reg, bux2_reg, buy2_reg;

    always_comb
    begin
        off_dx  = W_L'(a_offx_reg) - W_L'(b_offx_reg);
        off_dy  = W_L'(a_offy_reg) - W_L'(b_offy_reg);
        lx_next = (off_dx <<< ROT_SHIFT) + W_L'(a_exux_reg) - W_L'(a_eyuy_reg)
                  - W_L'(b_exux_reg) + W_L'(b_eyuy_reg);
        ly_next = (off_dy <<< ROT_SHIFT) + W_L'(a_exuy_reg) + W_L'(a_eyux_reg)
                  - W_L'(b_exuy_reg) - W_L'(b_eyux_reg);
        // squared lengths are never negative
        na_sum  = W_DOT'(sq_axx_reg) + W_DOT'(sq_ayy_reg);
        nb_sum  = W_DOT'(sq_bxx_reg) + W_DOT'(sq_byy_reg);
        na_next = na_sum[W_MAG-1:0];
        nb_next = nb_sum[W_MAG-1:0];
        // uA.uB and uA.perp(uB), all cross dots reduce to these
        p_sum   = W_DOT'(x_axbx_reg) + W_DOT'(x_ayby_reg);
        s_sum   = W_DOT'(x_axby_reg) - W_DOT'(x_aybx_reg);
        mp_next = abs_dot(p_sum);
        ms_next = abs_dot(s_sum);
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            lx_reg   <= lx_next;
            ly_reg   <= ly_next;
            na_reg   <= na_next;
            nb_reg   <= nb_next;
            mp_reg   <= mp_next;
            ms_reg   <= ms_next;
            aex2_reg <= aex1_reg;
            aey2_reg <= aey1_reg;
            bex2_reg <= bex1_reg;
            bey2_reg <= bey1_reg;
            aux2_reg <= aux1_reg;
            auy2_reg <= auy1_reg;
            bux2_reg <= bux1_reg;
            buy2_reg <= buy1_reg;
        end
    end

    // stages 3 and 4: one unit per axis
    obbt_stage_en_t          axis_en;
    logic signed [W_AX-1:0]  ax_ux, ax_uy, ax_nuy, bx_ux, bx_uy, bx_nuy;
    logic [N_AXES-1:0]       sep;

    assign axis_en.ld_prod = rdy3;
    assign axis_en.ld_sum  = rdy4;

    always_comb
    begin
        ax_ux  = W_AX'(aux2_reg);
        ax_uy  = W_AX'(auy2_reg);
        ax_nuy = -W_AX'(auy2_reg);
        bx_ux  = W_AX'(bux2_reg);
        bx_uy  = W_AX'(buy2_reg);
        bx_nuy = -W_AX'(buy2_reg);
    end

    // axis uA
    obbt_axis u_axis_a (
        .clk (clk),
        .en  (axis_en),
        .w0  (aex2_reg),
        .w1  (bex2_reg),
        .w2  (bey2_reg),
        .m0  (na_reg),
        .m1  (mp_reg),
        .m2  (ms_reg),
        .lx  (lx_reg),
        .ly  (ly_reg),
        .dx  (ax_ux),
        .dy  (ax_uy),
        .sep (sep[0])
    );

    // axis perp(uA)
    obbt_axis u_axis_ap (
        .clk (clk),
        .en  (axis_en),
        .w0  (aey2_reg),
        .w1  (bex2_reg),
        .w2  (bey2_reg),
        .m0  (na_reg),
        .m1  (ms_reg),
        .m2  (mp_reg),
        .lx  (lx_reg),
        .ly  (ly_reg),
        .dx  (ax_nuy),
        .dy  (ax_ux),
        .sep (sep[1])
    );

    // axis uB
    obbt_axis u_axis_b (
        .clk (clk),
        .en  (axis_en),
        .w0  (aex2_reg),
        .w1  (aey2_reg),
        .w2  (bex2_reg),
        .m0  (mp_reg),
        .m1  (ms_reg),
        .m2  (nb_reg),
        .lx  (lx_reg),
        .ly  (ly_reg),
        .dx  (bx_ux),
        .dy  (bx_uy),
        .sep (sep[2])
    );

    // axis perp(uB)
    obbt_axis u_axis_bp (
        .clk (clk),
        .en  (axis_en),
        .w0  (aex2_reg),
        .w1  (aey2_reg),
        .w2  (bey2_reg),
        .m0  (ms_reg),
        .m1  (mp_reg),
        .m2  (nb_reg),
        .lx  (lx_reg),
        .ly  (ly_reg),
        .dx  (bx_nuy),
        .dy  (bx_ux),
        .sep (sep[3])
    );

    // stage 5: overlap only when no axis separates
    logic overlap_reg, overlap_next;

    assign overlap_next = ~|sep;

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            overlap_reg <= overlap_next;
        end
    end

    assign m_axis_tvalid = v5_reg;
    assign m_axis_tdata  = {{(W_OUT_DATA - 1){1'b0}}, overlap_reg};

    // an accepted transaction always lands in stage 1
    `OBBT_ASSERT_NXT(a_accept_to_s1, s_axis_tvalid && s_axis_tready, v1_reg,
        "accepted transaction missing from stage 1")

    // a stalled stage 2 keeps its item and data
    `OBBT_ASSERT_NXT(a_s2_hold, v2_reg && !rdy3,
        v2_reg && $stable(lx_reg) && $stable(ly_reg) && $stable(mp_reg),
        "stalled stage 2 lost or changed its item")

    // an item leaving stage 4 reaches the output register
    `OBBT_ASSERT_NXT(a_s4_to_out, v4_reg && rdy5, m_axis_tvalid,
        "item from stage 4 did not reach the output")

    // ready upstream never asserts while a full stage 1 is blocked
    `OBBT_ASSERT_IMP(a_s1_block, v1_reg && !rdy2, !s_axis_tready,
        "input accepted into a blocked stage 1")

endmodule
